// ----- src/tsk_pkg.sv -----
// Shared types and codes for the tap-strafe key injector.
// Used by the controller, the datapath and the top level; no dependencies.
package tsk_pkg;

    // Item kinds carried in tuser.
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Input key codes.
    localparam logic [2:0] KEY_IN_A      = 3'd0;
    localparam logic [2:0] KEY_IN_D      = 3'd1;
    localparam logic [2:0] KEY_IN_W      = 3'd2;
    localparam logic [2:0] KEY_IN_SHIFT  = 3'd3;
    localparam logic [2:0] KEY_IN_NULL_A = 3'd4;
    localparam logic [2:0] KEY_IN_NULL_D = 3'd5;

    // Output key codes and actions.
    localparam logic [1:0] KEY_OUT_A = 2'd0;
    localparam logic [1:0] KEY_OUT_D = 2'd1;
    localparam logic [1:0] KEY_OUT_W = 2'd2;
    localparam logic       ACT_REG   = 1'b0;
    localparam logic       ACT_UNREG = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_VARIANCE = 2'd1;
    localparam logic [1:0] CFG_PRESS    = 2'd2;

    // Reset values.
    localparam logic [9:0]  INTERVAL_RST = 10'd20;
    localparam logic [6:0]  VARIANCE_RST = 7'd0;
    localparam logic [9:0]  PRESS_RST    = 10'd10;
    localparam logic [15:0] SEED_RST     = 16'hA361;

    // Bit steps of the jitter modulo, one per dividend bit.
    localparam int MOD_STEPS = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic eval;
        logic mod_step;
        logic finish;
    } tsk_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_mod;
        logic out_free;
    } tsk_sts_t;

endpackage

// ----- src/tsk_ctrl.sv -----
// Sequencer for the tap-strafe key injector: accept, evaluate, jitter modulo, finish.
// Depends on tsk_pkg for the command and status types.
module tsk_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tsk_pkg::tsk_sts_t sts,
    output tsk_pkg::tsk_cmd_t cmd
);
    import tsk_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_MOD,
        S_FIN
    } state_t;

    state_t     state_reg;
    logic [3:0] step_cnt_reg;

    // Command decode from the current state.
    assign s_tready     = (state_reg == S_IDLE);
    assign cmd.capture  = s_tvalid && (state_reg == S_IDLE);
    assign cmd.eval     = (state_reg == S_EVAL);
    assign cmd.mod_step = (state_reg == S_MOD);
    assign cmd.finish   = (state_reg == S_FIN) && sts.out_free;

    // State register and modulo step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                        state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    step_cnt_reg <= '0;
                    state_reg    <= sts.need_mod ? S_MOD : S_FIN;
                end
                S_MOD:
                begin
                    step_cnt_reg <= step_cnt_reg + 4'd1;
                    if (step_cnt_reg == 4'(MOD_STEPS - 1))
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (sts.out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/tsk_datapath.sv -----
// Datapath of the tap-strafe key injector: key state, timing, jitter draw and result buffer.
// Depends on tsk_pkg for codes and the command and status types.
module tsk_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  tsk_pkg::tsk_cmd_t cmd,
    output tsk_pkg::tsk_sts_t sts,
    input  logic [23:0]       s_tdata,
    input  logic [0:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [9:0]        cfg_data
);
    import tsk_pkg::*;

    localparam logic MODE_NOW       = 1'b0;
    localparam logic MODE_NOW_MINUS = 1'b1;

    // One step of the 16-bit xorshift generator.
    function automatic logic [15:0] xorshift16(input logic [15:0] s);
        logic [15:0] t;
        t = s ^ (s << 7);
        t = t ^ (t >> 9);
        t = t ^ (t << 8);
        return t;
    endfunction

    // Configuration registers.
    logic [9:0] interval_reg;
    logic [6:0] variance_reg;
    logic [9:0] press_reg;

    // Captured item.
    logic        op_reg;
    logic [2:0]  key_reg;
    logic        pr_reg;
    logic [15:0] now_reg;
    logic        layer_reg;

    // Key state.
    logic        a_down_reg, d_down_reg, w_phys_reg, shift_reg, w_inj_reg;
    logic [15:0] start_reg;
    logic [15:0] cur_int_reg;
    logic [15:0] seed_reg;

    // Evaluation results held until finish.
    logic        draw_reg;
    logic        mode_reg;
    logic [1:0]  res_n_reg;
    logic [2:0]  res0_reg, res1_reg;

    // Modulo unit.
    logic [15:0] div_reg;
    logic [7:0]  rem_reg;

    // Output buffer: entries hold {last, key, action}.
    logic [1:0]  out_cnt_reg;
    logic [3:0]  buf0_reg, buf1_reg;

    // Combinational evaluation signals.
    logic        a_next, d_next, w_phys_next, shift_next, w_inj_next;
    logic        draw_next, mode_next;
    logic [1:0]  res_n_next;
    logic [2:0]  res0_next, res1_next;
    logic        was_moving, should;
    logic [15:0] elapsed;
    logic [15:0] seed_next;
    logic [7:0]  range;
    logic [8:0]  trial;
    logic [15:0] interval_new;

    assign range     = {variance_reg, 1'b1};
    assign elapsed   = now_reg - start_reg;
    assign seed_next = xorshift16(seed_reg ^ now_reg);
    assign trial     = {rem_reg, div_reg[15]};

    // Decide the results and the new flags from the item and the old state.
    always_comb
    begin
        a_next      = a_down_reg;
        d_next      = d_down_reg;
        w_phys_next = w_phys_reg;
        shift_next  = shift_reg;
        w_inj_next  = w_inj_reg;
        draw_next   = 1'b0;
        mode_next   = MODE_NOW;
        res_n_next  = 2'd0;
        res0_next   = 3'd0;
        res1_next   = 3'd0;
        was_moving  = a_down_reg || d_down_reg;
        should      = layer_reg && was_moving && !shift_reg;
        if (op_reg == OP_KEY)
        begin
            case (key_reg)
                KEY_IN_NULL_A:
                begin
                    res0_next  = {KEY_OUT_A, pr_reg ? ACT_REG : ACT_UNREG};
                    res1_next  = {KEY_OUT_D, pr_reg ? ACT_UNREG : ACT_REG};
                    res_n_next = d_down_reg ? 2'd2 : 2'd1;
                    a_next     = pr_reg;
                end
                KEY_IN_A:
                begin
                    a_next = pr_reg;
                end
                KEY_IN_NULL_D:
                begin
                    res0_next  = {KEY_OUT_D, pr_reg ? ACT_REG : ACT_UNREG};
                    res1_next  = {KEY_OUT_A, pr_reg ? ACT_UNREG : ACT_REG};
                    res_n_next = a_down_reg ? 2'd2 : 2'd1;
                    d_next     = pr_reg;
                end
                KEY_IN_D:
                begin
                    d_next = pr_reg;
                end
                KEY_IN_W:
                begin
                    w_phys_next = pr_reg;
                    if (pr_reg)
                        w_inj_next = 1'b0;
                    draw_next = 1'b1;
                end
                KEY_IN_SHIFT:
                begin
                    shift_next = pr_reg;
                    draw_next  = 1'b1;
                end
                default:
                begin
                end
            endcase
            // The first strafe key starts a full interval in the past.
            if (!was_moving && (a_next || d_next))
            begin
                draw_next = 1'b1;
                mode_next = MODE_NOW_MINUS;
            end
        end
        else if (!should || w_phys_reg)
        begin
            if (w_inj_reg)
            begin
                if (!w_phys_reg)
                begin
                    res0_next  = {KEY_OUT_W, ACT_UNREG};
                    res_n_next = 2'd1;
                end
                w_inj_next = 1'b0;
            end
        end
        else if (w_inj_reg)
        begin
            if (elapsed >= {6'd0, press_reg})
            begin
                res0_next  = {KEY_OUT_W, ACT_UNREG};
                res_n_next = 2'd1;
                w_inj_next = 1'b0;
            end
        end
        else if (elapsed >= cur_int_reg)
        begin
            draw_next  = 1'b1;
            res0_next  = {KEY_OUT_W, ACT_REG};
            res_n_next = 2'd1;
            w_inj_next = 1'b1;
        end
    end

    assign sts.need_mod = draw_next && (variance_reg != 7'd0);
    assign sts.out_free = (out_cnt_reg == 2'd0);

    // New interval from the nominal value and the jitter remainder.
    assign interval_new = (variance_reg == 7'd0) ? {6'd0, interval_reg}
                        : ({6'd0, interval_reg} - {9'd0, variance_reg} + {8'd0, rem_reg});

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RST;
            variance_reg <= VARIANCE_RST;
            press_reg    <= PRESS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INTERVAL: interval_reg <= cfg_data;
                CFG_VARIANCE: variance_reg <= cfg_data[6:0];
                CFG_PRESS:    press_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Item capture, evaluation results and the modulo unit.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= s_tuser[0];
            key_reg   <= s_tdata[2:0];
            pr_reg    <= s_tdata[3];
            now_reg   <= s_tdata[19:4];
            layer_reg <= s_tdata[20];
        end
        if (cmd.eval)
        begin
            draw_reg  <= draw_next;
            mode_reg  <= mode_next;
            res_n_reg <= res_n_next;
            res0_reg  <= res0_next;
            res1_reg  <= res1_next;
            div_reg   <= seed_next;
            rem_reg   <= '0;
        end
        else if (cmd.mod_step)
        begin
            div_reg <= {div_reg[14:0], 1'b0};
            if (trial >= {1'b0, range})
                rem_reg <= 8'(trial - {1'b0, range});
            else
                rem_reg <= trial[7:0];
        end
    end

    // Key state and timing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_down_reg  <= 1'b0;
            d_down_reg  <= 1'b0;
            w_phys_reg  <= 1'b0;
            shift_reg   <= 1'b0;
            w_inj_reg   <= 1'b0;
            start_reg   <= '0;
            cur_int_reg <= {6'd0, INTERVAL_RST};
            seed_reg    <= SEED_RST;
        end
        else
        begin
            if (cmd.eval)
            begin
                a_down_reg <= a_next;
                d_down_reg <= d_next;
                w_phys_reg <= w_phys_next;
                shift_reg  <= shift_next;
                w_inj_reg  <= w_inj_next;
                if (sts.need_mod)
                    seed_reg <= seed_next;
            end
            if (cmd.finish && draw_reg)
            begin
                cur_int_reg <= interval_new;
                start_reg   <= (mode_reg == MODE_NOW_MINUS) ? (now_reg - interval_new) : now_reg;
            end
        end
    end

    // Result buffer, loaded only when empty and drained one item per handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg <= 2'd0;
        end
        else if (cmd.finish)
        begin
            out_cnt_reg <= res_n_reg;
        end
        else if (m_tvalid && m_tready)
        begin
            out_cnt_reg <= out_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            buf0_reg <= {res_n_reg == 2'd1, res0_reg};
            buf1_reg <= {1'b1, res1_reg};
        end
        else if (m_tvalid && m_tready)
        begin
            buf0_reg <= buf1_reg;
        end
    end

    assign m_tvalid = (out_cnt_reg != 2'd0);
    assign m_tdata  = {5'd0, buf0_reg[2:0]};
    assign m_tlast  = buf0_reg[3];

    // The buffer holds at most the two results of one item.
    assert property (@(posedge clk) disable iff (!rst_n) out_cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    // A finished jitter draw leaves a remainder below the range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && draw_reg && variance_reg != 7'd0) |-> ({1'b0, rem_reg} < {1'b0, range}))
        else $error("jitter remainder not below range");

    // An injected W only starts on a scan tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(w_inj_reg) |-> $past(op_reg == OP_TICK))
        else $error("injected W set by a key event");

    // The buffer is never reloaded while results still wait.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (out_cnt_reg == 2'd0))
        else $error("result buffer overwritten");

endmodule

// ----- src/tap_strafe_key_injector.sv -----
// Tap-strafe key injector: key event and scan tick items in, key register/unregister items out.
// An item is evaluated in the cycle after acceptance; the modulo state then runs the
// 16-step bit-serial modulo when a jittered interval is drawn, and the finish state loads
// the results into the output buffer. A new item is accepted only in the idle state.
// A new item is taken while earlier results wait; finishing waits for the output buffer to empty.
// Reset (rst_n low, asynchronous) restores all key state, the config registers and the seed at once.
module tap_strafe_key_injector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // key[2:0], pressed[3], now_ms[19:4], strafe_layer_on[20]
    input  logic [0:0]  s_tuser,   // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // action[0], out_key[2:1]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    import tsk_pkg::*;

    tsk_cmd_t cmd;
    tsk_sts_t sts;

    // Registers accept a write in every cycle.
    assign cfg_ready = 1'b1;

    tsk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tsk_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
